// File: src/csa_pkg.sv
// shared constants, types and codes of the connection slot allocator
package csa_pkg;

  localparam int SLOTS          = 16;
  localparam int CLIENT_ENTRIES = 8;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLI_W    = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int SCAN_W   = (SLOT_W > CLI_W) ? SLOT_W : CLI_W;
  localparam int CNT_W    = $clog2(CLIENT_ENTRIES + 1);

  localparam int MPC_W      = 5;
  localparam int MC_W       = 4;
  localparam int PORT_W     = 16;
  localparam int ID_W       = 16;
  localparam int HELD_W     = 5;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PROD_W = MPC_W + MC_W;
  localparam int LIM_W  = (CNT_W > MC_W) ? CNT_W : MC_W;

  typedef enum logic [0:0] {
    OP_RESERVE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_CLIENTS_FULL = 3'd1,
    ST_QUOTA        = 3'd2,
    ST_NO_SLOT      = 3'd3,
    ST_NOT_FOUND    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PER_CLIENT = 2'd0,
    CFG_MAX_CLIENTS    = 2'd1,
    CFG_PORT_BASE      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [HELD_W-1:0] held;
    logic [ID_W-1:0]   key;
  } cli_ent_t;

  typedef struct packed {
    logic              start;
    logic [SCAN_W-1:0] last;
  } scan_req_t;

  typedef struct packed {
    logic              busy;
    logic              found;
    logic [SCAN_W-1:0] idx;
  } scan_rsp_t;

endpackage

// File: src/csa_ram.sv
// generic single-port-write ram with registered read
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/csa_scan.sv
// sequential lookup over a ram, one entry read per cycle, stops at first hit or at the last entry
module csa_scan import csa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_req_t         req_i,
  input  logic              hit_i,
  output logic              rd_en_o,
  output logic [SCAN_W-1:0] rd_addr_o,
  output scan_rsp_t         rsp_o
);

  logic              busy_q;
  logic              cmp_vld_q;
  logic              found_q;
  logic [SCAN_W-1:0] rd_idx_q;
  logic [SCAN_W-1:0] cmp_idx_q;
  logic [SCAN_W-1:0] last_q;
  logic              fin;

  assign fin     = busy_q && cmp_vld_q && (hit_i || (cmp_idx_q == last_q));
  assign rd_en_o = busy_q && !fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (req_i.start) begin
      busy_q    <= 1'b1;
      cmp_vld_q <= 1'b0;
    end else if (fin) begin
      busy_q    <= 1'b0;
      found_q   <= hit_i;
    end else if (busy_q) begin
      cmp_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rd_idx_q <= '0;
      last_q   <= req_i.last;
    end else if (rd_en_o) begin
      cmp_idx_q <= rd_idx_q;
      rd_idx_q  <= (rd_idx_q == last_q) ? rd_idx_q : rd_idx_q + 1'b1;
    end
  end

  assign rd_addr_o   = rd_idx_q;
  assign rsp_o.busy  = busy_q;
  assign rsp_o.found = found_q;
  assign rsp_o.idx   = cmp_idx_q;

endmodule

// File: src/connection_slot_allocator_core.sv
// connection slot allocator: shared slot pool with per-client quota
//
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tdata: client_id, port; tuser: opcode
// m_axis   out  m_axis_tvalid/tready       tdata: granted_port; tuser: status
// cfg      in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// one request at a time; the client table and the slot owner ram are scanned
// one entry a cycle, both in parallel on a release
// busy slots and valid clients sit in flip-flops cleared by reset, no sweep
// a beat waiting on m_axis_tready holds the next request in S_OUT until it leaves
module connection_slot_allocator_core import csa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // client_id, port
  input  logic [0:0]            s_axis_tuser,  // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // granted_port
  output logic [STATUS_W-1:0]   m_axis_tuser,  // status
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [MPC_W-1:0]  mpc_q;
  logic [MC_W-1:0]   mc_q;
  logic [PORT_W-1:0] pb_q;

  state_e state_q, state_d;
  logic [SLOTS-1:0]          slot_busy_q, slot_busy_d;
  logic [CLIENT_ENTRIES-1:0] cli_valid_q, cli_valid_d;

  opcode_e           op_q;
  logic [ID_W-1:0]   id_q;
  logic [PORT_W-1:0] port_q;

  status_e           res_status_q, res_status_d;
  logic [PORT_W-1:0] res_port_q, res_port_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [PORT_W-1:0] out_port_q;
  logic              out_load;
  logic              in_ready;

  scan_req_t         cli_req, slot_req;
  scan_rsp_t         cli_rsp, slot_rsp;
  logic              cli_hit, slot_hit;
  logic              cli_re, slot_re;
  logic [SCAN_W-1:0] cli_raddr, slot_raddr;

  logic              cli_we, slot_we;
  logic [CLI_W-1:0]  cli_waddr;
  cli_ent_t          cli_wdata;
  cli_ent_t          cli_rdata;
  logic [SLOT_W-1:0] slot_waddr;
  logic [ID_W-1:0]   owner_rdata;

  logic [CLI_W-1:0]  cli_idx;
  logic [SLOT_W-1:0] slot_idx;

  logic [CLI_W-1:0]  free_cli;
  logic [SLOT_W-1:0] free_slot;
  logic              free_slot_ok;
  logic [PROD_W-1:0] prod, pool;
  logic [LIM_W-1:0]  cli_cnt, cli_lim;
  logic [HELD_W-1:0] held_dec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpc_q <= MPC_W'(1);
      mc_q  <= MC_W'(1);
      pb_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_PER_CLIENT: mpc_q <= cfg_data_i[MPC_W-1:0];
        CFG_MAX_CLIENTS:    mc_q  <= cfg_data_i[MC_W-1:0];
        CFG_PORT_BASE:      pb_q  <= cfg_data_i[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cli_idx  = cli_rsp.idx[CLI_W-1:0];
  assign slot_idx = slot_rsp.idx[SLOT_W-1:0];

  assign cli_hit  = cli_valid_q[cli_idx] && (cli_rdata.key == id_q);
  assign slot_hit = slot_busy_q[slot_idx] && (owner_rdata == id_q) &&
                    ((pb_q + {{(PORT_W-SLOT_W){1'b0}}, slot_idx}) == port_q);

  csa_scan u_cli_scan (
    .clk_i,
    .rst_ni,
    .req_i     (cli_req),
    .hit_i     (cli_hit),
    .rd_en_o   (cli_re),
    .rd_addr_o (cli_raddr),
    .rsp_o     (cli_rsp)
  );

  csa_scan u_slot_scan (
    .clk_i,
    .rst_ni,
    .req_i     (slot_req),
    .hit_i     (slot_hit),
    .rd_en_o   (slot_re),
    .rd_addr_o (slot_raddr),
    .rsp_o     (slot_rsp)
  );

  csa_ram #(.WIDTH($bits(cli_ent_t)), .DEPTH(CLIENT_ENTRIES)) u_cli_ram (
    .clk_i,
    .we_i    (cli_we),
    .waddr_i (cli_waddr),
    .wdata_i (cli_wdata),
    .re_i    (cli_re),
    .raddr_i (cli_raddr[CLI_W-1:0]),
    .rdata_o (cli_rdata)
  );

  csa_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_owner_ram (
    .clk_i,
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (id_q),
    .re_i    (slot_re),
    .raddr_i (slot_raddr[SLOT_W-1:0]),
    .rdata_o (owner_rdata)
  );

  // pool size, client limit and lowest free entries
  always_comb begin
    prod    = PROD_W'(mpc_q) * PROD_W'(mc_q);
    pool    = (prod > PROD_W'(SLOTS)) ? PROD_W'(SLOTS) : prod;
    cli_cnt = LIM_W'($countones(cli_valid_q));
    cli_lim = (LIM_W'(mc_q) > LIM_W'(CLIENT_ENTRIES)) ? LIM_W'(CLIENT_ENTRIES)
                                                       : LIM_W'(mc_q);
    free_slot    = '0;
    free_slot_ok = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy_q[i] && (PROD_W'(i) < pool)) begin
        free_slot    = SLOT_W'(i);
        free_slot_ok = 1'b1;
      end
    end
    free_cli = '0;
    for (int e = CLIENT_ENTRIES - 1; e >= 0; e--) begin
      if (!cli_valid_q[e]) begin
        free_cli = CLI_W'(e);
      end
    end
    held_dec = (cli_rdata.held != '0) ? cli_rdata.held - 1'b1 : '0;
  end

  always_comb begin
    state_d       = state_q;
    slot_busy_d   = slot_busy_q;
    cli_valid_d   = cli_valid_q;
    res_status_d  = res_status_q;
    res_port_d    = res_port_q;
    cli_req.start = 1'b0;
    cli_req.last  = SCAN_W'(CLIENT_ENTRIES - 1);
    slot_req.start = 1'b0;
    slot_req.last  = SCAN_W'(SLOTS - 1);
    cli_we        = 1'b0;
    cli_waddr     = cli_idx;
    cli_wdata.key = id_q;
    cli_wdata.held = cli_rdata.held + 1'b1;
    slot_we       = 1'b0;
    slot_waddr    = free_slot;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (s_axis_tvalid) begin
          cli_req.start  = 1'b1;
          slot_req.start = (s_axis_tuser[0] == OP_RELEASE);
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!cli_rsp.busy && !slot_rsp.busy) begin
          state_d    = S_OUT;
          res_port_d = '0;
          if (op_q == OP_RESERVE) begin
            priority if (cli_cnt >= cli_lim) begin
              res_status_d = ST_CLIENTS_FULL;
            end else if (cli_rsp.found && (cli_rdata.held >= mpc_q)) begin
              res_status_d = ST_QUOTA;
            end else if (!free_slot_ok) begin
              res_status_d = ST_NO_SLOT;
            end else begin
              res_status_d = ST_OK;
              res_port_d   = pb_q + {{(PORT_W-SLOT_W){1'b0}}, free_slot};
              slot_we      = 1'b1;
              slot_busy_d[free_slot] = 1'b1;
              cli_we       = 1'b1;
              if (!cli_rsp.found) begin
                cli_waddr      = free_cli;
                cli_wdata.held = HELD_W'(1);
                cli_valid_d[free_cli] = 1'b1;
              end
            end
          end else begin
            if (!slot_rsp.found) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              res_status_d = ST_OK;
              slot_busy_d[slot_idx] = 1'b0;
              if (cli_rsp.found) begin
                cli_we         = 1'b1;
                cli_wdata.held = held_dec;
                if (held_dec == '0) begin
                  cli_valid_d[cli_idx] = 1'b0;
                end
              end
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_busy_q <= '0;
      cli_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_busy_q <= slot_busy_d;
      cli_valid_q <= cli_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      op_q   <= opcode_e'(s_axis_tuser[0]);
      id_q   <= s_axis_tdata[ID_W-1:0];
      port_q <= s_axis_tdata[ID_W+PORT_W-1:ID_W];
    end
    res_status_q <= res_status_d;
    res_port_q   <= res_port_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_port_q   <= res_port_q;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_port_q;
  assign m_axis_tuser  = out_status_q;

  a_idle_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!cli_rsp.busy && !slot_rsp.busy))
    else $error("scan still running while idle");

  a_beat_after_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result beat without a finished request");

  a_clients_hold_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_busy_q) >= $countones(cli_valid_q))
    else $error("listed client without a busy slot");

  a_refused_no_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("port granted on a refused request");

endmodule
